>>> rtl/core/gesture_segmenter_resampler_defines.svh
// Assertion macros used by the checker file.
`ifndef GESTURE_SEGMENTER_RESAMPLER_DEFINES_SVH
`define GESTURE_SEGMENTER_RESAMPLER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define GSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define GSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gsr_pkg.sv
`default_nettype none
package gsr_pkg;

    localparam int MAX_FRAMES_DEF = 37;
    localparam int OUT_FRAMES_DEF = 20;
    localparam int PIXELS_DEF     = 9;

    localparam int NUM_PIX     = 9;
    localparam int PIX_W       = 10;
    localparam int OUT_W       = 15;
    localparam int SUM_W       = 14;
    localparam int BASE_W      = 30;
    localparam int MULA_W      = 30;
    localparam int MULB_W      = 17;
    localparam int PROD_W      = 47;
    localparam int FRAC_W      = 5;
    localparam int IDX_OUT_W   = 5;
    localparam int IDLE_KEEP   = 3;
    localparam int QUIET_FRAMES = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] EMA_WEIGHT_RST  = 16'd6554;
    localparam logic [15:0] BAND_MARGIN_RST = 16'd6554;
    localparam logic [9:0]  PIX_LIMIT_RST   = 10'd51;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_WEIGHT  = 2'd0,
        CFG_BAND_MARGIN = 2'd1,
        CFG_PIX_LIMIT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MLO,
        ST_MHI,
        ST_CMP,
        ST_EMA,
        ST_EMB,
        ST_EMC,
        ST_POST,
        ST_CPRD,
        ST_CPWR,
        ST_DIV,
        ST_GA,
        ST_GB,
        ST_GC,
        ST_GW
    } gsr_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix0;
        logic [PIX_W-1:0] pix1;
        logic [PIX_W-1:0] pix2;
        logic [PIX_W-1:0] pix3;
        logic [PIX_W-1:0] pix4;
        logic [PIX_W-1:0] pix5;
        logic [PIX_W-1:0] pix6;
        logic [PIX_W-1:0] pix7;
        logic [PIX_W-1:0] pix8;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]     out0;
        logic [OUT_W-1:0]     out1;
        logic [OUT_W-1:0]     out2;
        logic [OUT_W-1:0]     out3;
        logic [OUT_W-1:0]     out4;
        logic [OUT_W-1:0]     out5;
        logic [OUT_W-1:0]     out6;
        logic [OUT_W-1:0]     out7;
        logic [OUT_W-1:0]     out8;
        logic [IDX_OUT_W-1:0] sample_index;
        logic                 last_frame;
    } out_item_t;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0] frame_t;
    typedef logic [NUM_PIX-1:0][OUT_W-1:0] pix_out_t;

    typedef struct packed {
        logic [MULA_W-1:0] a;
        logic [MULB_W-1:0] b;
    } mul_req_t;

    function automatic frame_t to_frame(input in_item_t d);
        frame_t f;
        f[0] = d.pix0;
        f[1] = d.pix1;
        f[2] = d.pix2;
        f[3] = d.pix3;
        f[4] = d.pix4;
        f[5] = d.pix5;
        f[6] = d.pix6;
        f[7] = d.pix7;
        f[8] = d.pix8;
        return f;
    endfunction

    function automatic logic [SUM_W-1:0] frame_sum(input frame_t f);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int j = 0; j < NUM_PIX; j++) begin
            s = s + SUM_W'(f[j]);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/gesture_segmenter_resampler.sv
// Accepts one 3x3 frame at a time and is busy until it is done: each frame runs ST_SUM,
// ST_MLO-ST_CMP unless it (re)initializes, ST_EMA-ST_EMC if the baseline adapts, ST_POST,
// and ST_CPRD/ST_CPWR per frame kept if the idle store is cut to its last three frames.
// Band, EMA and reciprocal products use one registered 30x17 multiplier, one per cycle.
// On the third quiet frame after a gesture the block derives the position step in ST_DIV
// from a reciprocal product in the same multiplier, then emits OUT_FRAMES resampled frames
// via ST_GA-ST_GW, held in ST_GW while the output stalls, two reads of the frame memory's
// one read port per result. The store has no reset; only written entries are used.
`default_nettype none
module gesture_segmenter_resampler
    import gsr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int OUT_FRAMES = OUT_FRAMES_DEF,
    parameter int PIXELS     = PIXELS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int AW    = $clog2(MAX_FRAMES);
    localparam int IW    = $clog2(OUT_FRAMES);
    localparam int DEN   = OUT_FRAMES - 1;
    localparam int DENW  = $clog2(DEN + 1);
    localparam int RW    = DENW + 1;
    localparam int QW    = CW + FRAC_W;
    localparam int KSH   = QW + DENW;
    localparam int RECIP = (2 ** KSH) / DEN + 1;

    gsr_state_t state_reg, state_next;

    logic [15:0]       alpha_reg, margin_reg;
    logic [PIX_W-1:0]  limit_reg;

    frame_t            cur_reg, cur_next;
    frame_t            ref_reg, ref_next;
    frame_t            fa_reg, fa_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              active_reg, active_next;
    logic [1:0]        cd_reg, cd_next;
    logic              init_reg, init_next;
    logic [SUM_W-1:0]  s_reg, s_next;
    logic              dev_reg, dev_next;
    logic [PROD_W-1:0] lo_reg, lo_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [1:0]        k_reg, k_next;
    logic [QW-1:0]     div_reg, div_next;
    logic [DENW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DENW-1:0]   r_reg, r_next;
    logic [IW-1:0]     idx_reg, idx_next;
    out_item_t         out_reg, out_next;
    logic              ov_reg, ov_next;

    frame_t            in_frame;
    logic [SUM_W-1:0]  s_c;
    logic              dev_c;
    logic [CW-1:0]     slot;
    logic [CW-1:0]     a_c;
    logic [CW-1:0]     b_c;
    logic [FRAC_W-1:0] f_c;
    logic [PROD_W-1:0] s32;
    logic              in_band;
    logic              keep_idle;
    logic [47:0]       ema_sum;
    logic [QW-1:0]     num_c;
    logic [QW-1:0]     quo_c;
    logic [QW-1:0]     rem_c;
    logic [RW-1:0]     rsum;
    logic [CW-1:0]     copy_src;
    pix_out_t          lerp_val;

    mul_req_t          mreq;
    logic [PROD_W-1:0] prod;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    frame_t            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    frame_t            mem_rdata;

    gsr_frame_store #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gsr_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    gsr_lerp u_lerp (
        .fa   (fa_reg),
        .fb   (mem_rdata),
        .frac (f_c),
        .val  (lerp_val)
    );

    always_comb
    begin
        in_frame = to_frame(in_data);
        for (int j = 0; j < NUM_PIX; j++)
        begin
            if (j >= PIXELS)
            begin
                in_frame[j] = '0;
            end
        end
    end

    always_comb
    begin
        dev_c = 1'b0;
        for (int j = 0; j < NUM_PIX; j++)
        begin
            if (cur_reg[j] > ref_reg[j])
            begin
                dev_c = dev_c | ((cur_reg[j] - ref_reg[j]) > limit_reg);
            end
            else
            begin
                dev_c = dev_c | ((ref_reg[j] - cur_reg[j]) > limit_reg);
            end
        end
    end

    assign s_c       = frame_sum(cur_reg);
    assign slot      = (count_reg < CW'(MAX_FRAMES)) ? count_reg : CW'(MAX_FRAMES - 1);
    assign a_c       = q_reg[QW-1:FRAC_W];
    assign f_c       = q_reg[FRAC_W-1:0];
    assign b_c       = ((f_c != '0) && ((a_c + CW'(1)) < count_reg)) ? a_c + CW'(1) : a_c;
    assign s32       = PROD_W'({s_reg, 32'b0});
    assign in_band   = (s32 >= lo_reg) && (s32 <= prod);
    assign keep_idle = !active_reg && (cd_reg == 2'd0) && (count_reg > CW'(IDLE_KEEP));
    assign ema_sum   = {1'b0, acc_reg} + {prod[31:0], 16'b0};
    assign num_c     = {count_reg - CW'(1), {FRAC_W{1'b0}}};
    assign quo_c     = prod[KSH +: QW];
    assign rem_c     = num_c - quo_c * QW'(DEN);
    assign rsum      = {1'b0, r_reg} + {1'b0, rem_reg};
    assign copy_src  = count_reg - CW'(IDLE_KEEP) + CW'(k_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_SUM;
            ST_SUM:  state_next = init_reg ? ST_POST : ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_CMP;
            ST_CMP:  state_next = (in_band && dev_reg) ? ST_EMA : ST_POST;
            ST_EMA:  state_next = ST_EMB;
            ST_EMB:  state_next = ST_EMC;
            ST_EMC:  state_next = ST_POST;
            ST_POST:
            begin
                priority if (cd_reg == 2'd1) state_next = ST_DIV;
                else if (keep_idle)          state_next = ST_CPRD;
                else                         state_next = ST_IDLE;
            end
            ST_CPRD: state_next = ST_CPWR;
            ST_CPWR: state_next = (k_reg == 2'd2) ? ST_IDLE : ST_CPRD;
            ST_DIV:  state_next = ST_GA;
            ST_GA:   state_next = ST_GB;
            ST_GB:   state_next = ST_GC;
            ST_GC:   state_next = ST_GW;
            ST_GW:
            begin
                if (out_ready)
                begin
                    state_next = (idx_reg == IW'(OUT_FRAMES - 1)) ? ST_IDLE : ST_GA;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory, multiplier and handshake controls
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = slot[AW-1:0];
        mem_wdata = in_frame;
        mem_raddr = '0;
        mreq.a    = base_reg;
        mreq.b    = '0;
        unique case (state_reg)
            ST_IDLE: mem_we = in_valid;
            ST_MLO:  mreq.b = 17'h10000 - {1'b0, margin_reg};
            ST_MHI:  mreq.b = {1'b1, margin_reg};
            ST_EMA:  mreq.b = 17'h10000 - {1'b0, alpha_reg};
            ST_EMB:
            begin
                mreq.a = MULA_W'(s_reg);
                mreq.b = {1'b0, alpha_reg};
            end
            ST_POST:
            begin
                if (cd_reg == 2'd1)
                begin
                    mreq.a = MULA_W'(RECIP);
                    mreq.b = MULB_W'(num_c);
                end
            end
            ST_CPRD: mem_raddr = copy_src[AW-1:0];
            ST_CPWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(k_reg);
                mem_wdata = mem_rdata;
            end
            ST_GA:   mem_raddr = a_c[AW-1:0];
            ST_GB:   mem_raddr = b_c[AW-1:0];
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        cur_next    = cur_reg;
        ref_next    = ref_reg;
        fa_next     = fa_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        active_next = active_reg;
        cd_next     = cd_reg;
        init_next   = init_reg;
        s_next      = s_reg;
        dev_next    = dev_reg;
        lo_next     = lo_reg;
        acc_next    = acc_reg;
        k_next      = k_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        idx_next    = idx_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next   = in_frame;
                    count_next = slot + CW'(1);
                end
            end
            ST_SUM:
            begin
                s_next   = s_c;
                dev_next = dev_c;
                if (init_reg)
                begin
                    base_next = {s_c, 16'b0};
                    ref_next  = cur_reg;
                    init_next = 1'b0;
                end
            end
            ST_MHI: lo_next = prod;
            ST_CMP:
            begin
                if (in_band)
                begin
                    if (active_reg)
                    begin
                        cd_next     = 2'(QUIET_FRAMES);
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    active_next = 1'b1;
                end
            end
            ST_EMB: acc_next  = prod;
            ST_EMC: base_next = ema_sum[45:16];
            ST_POST:
            begin
                if (cd_reg != 2'd0)
                begin
                    cd_next = cd_reg - 2'd1;
                end
                priority if (cd_reg == 2'd1)
                begin
                    q_next   = '0;
                    r_next   = '0;
                    idx_next = '0;
                end
                else if (keep_idle)
                begin
                    k_next = '0;
                end
                else if (count_reg > CW'(MAX_FRAMES - 3))
                begin
                    base_next   = {s_reg, 16'b0};
                    ref_next    = cur_reg;
                    active_next = 1'b0;
                    cd_next     = '0;
                    count_next  = '0;
                    init_next   = 1'b1;
                end
            end
            ST_CPWR:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    count_next = CW'(IDLE_KEEP);
                end
            end
            ST_DIV:
            begin
                div_next = quo_c;
                rem_next = DENW'(rem_c);
            end
            ST_GB: fa_next = mem_rdata;
            ST_GC:
            begin
                out_next.out0         = lerp_val[0];
                out_next.out1         = lerp_val[1];
                out_next.out2         = lerp_val[2];
                out_next.out3         = lerp_val[3];
                out_next.out4         = lerp_val[4];
                out_next.out5         = lerp_val[5];
                out_next.out6         = lerp_val[6];
                out_next.out7         = lerp_val[7];
                out_next.out8         = lerp_val[8];
                out_next.sample_index = IDX_OUT_W'(idx_reg);
                out_next.last_frame   = (idx_reg == IW'(OUT_FRAMES - 1));
                ov_next               = 1'b1;
            end
            ST_GW:
            begin
                if (out_ready)
                begin
                    ov_next  = 1'b0;
                    idx_next = idx_reg + IW'(1);
                    if (rsum >= RW'(DEN))
                    begin
                        r_next = DENW'(rsum - RW'(DEN));
                        q_next = q_reg + div_reg + QW'(1);
                    end
                    else
                    begin
                        r_next = rsum[DENW-1:0];
                        q_next = q_reg + div_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ov_reg     <= 1'b0;
            count_reg  <= '0;
            base_reg   <= '0;
            ref_reg    <= '0;
            active_reg <= 1'b0;
            cd_reg     <= '0;
            init_reg   <= 1'b1;
            alpha_reg  <= EMA_WEIGHT_RST;
            margin_reg <= BAND_MARGIN_RST;
            limit_reg  <= PIX_LIMIT_RST;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            count_reg  <= count_next;
            base_reg   <= base_next;
            ref_reg    <= ref_next;
            active_reg <= active_next;
            cd_reg     <= cd_next;
            init_reg   <= init_next;
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_EMA_WEIGHT:  alpha_reg  <= cfg_data;
                    CFG_BAND_MARGIN: margin_reg <= cfg_data;
                    CFG_PIX_LIMIT:   limit_reg  <= cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        fa_reg   <= fa_next;
        s_reg    <= s_next;
        dev_reg  <= dev_next;
        lo_reg   <= lo_next;
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

>>> rtl/core/gsr_frame_store.sv
`default_nettype none
module gsr_frame_store
    import gsr_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int AW    = $clog2(MAX_FRAMES_DEF)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  frame_t        wdata,
    input  logic [AW-1:0] raddr,
    output frame_t        rdata
);

    frame_t mem_array [DEPTH];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/gsr_mul.sv
`default_nettype none
module gsr_mul
    import gsr_pkg::*;
(
    input  logic              clk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> rtl/core/gsr_lerp.sv
`default_nettype none
module gsr_lerp
    import gsr_pkg::*;
(
    input  frame_t            fa,
    input  frame_t            fb,
    input  logic [FRAC_W-1:0] frac,
    output pix_out_t          val
);

    logic [FRAC_W:0] w0;
    logic [16:0]     t;

    always_comb
    begin
        w0 = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};
        t  = '0;
        for (int j = 0; j < NUM_PIX; j++)
        begin
            t      = 17'(fa[j]) * 17'(w0) + 17'(fb[j]) * 17'(frac);
            val[j] = t[OUT_W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/gsr_checker.sv
`default_nettype none
`include "gesture_segmenter_resampler_defines.svh"
module gsr_checker
    import gsr_pkg::*;
#(
    parameter int OUT_FRAMES = OUT_FRAMES_DEF
)(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `GSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output item changed")
    `GSR_ASSERT(a_no_input_while_output, out_valid |-> !in_ready, "input taken during output")
    `GSR_ASSERT_NEXT(a_busy_after_input, in_valid && in_ready, !in_ready, "ready right after input item")
    `GSR_ASSERT_NEXT(a_last_ends_burst, out_valid && out_ready && out_data.last_frame, !out_valid, "output continued after last frame")
    `GSR_ASSERT(a_last_index, (out_valid && out_data.last_frame) |-> (out_data.sample_index == 5'(OUT_FRAMES - 1)), "last frame at wrong index")

endmodule

bind gesture_segmenter_resampler gsr_checker #(
    .OUT_FRAMES (OUT_FRAMES)
) u_gsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import gsr_pkg::*;

    localparam int MAXF = 37;
    localparam int OUTF = 20;

    class gesture_scoreboard;
        logic [9:0]  store [MAXF][9];
        int unsigned n_stored;
        logic [63:0] base_q16;
        logic [9:0]  ref_frame [9];
        bit          active;
        int unsigned countdown;
        bit          init_pend;
        logic [15:0] alpha;
        logic [15:0] margin;
        logic [9:0]  dev_limit;
        out_item_t   expected_frames [$];
        int          errors;

        function void reset_state();
            n_stored = 0;
            base_q16 = 0;
            active = 0;
            countdown = 0;
            init_pend = 1;
            alpha = EMA_WEIGHT_RST;
            margin = BAND_MARGIN_RST;
            dev_limit = PIX_LIMIT_RST;
            errors = 0;
            for (int j = 0; j < 9; j++)
            begin
                ref_frame[j] = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_EMA_WEIGHT:  alpha = v;
                CFG_BAND_MARGIN: margin = v;
                CFG_PIX_LIMIT:   dev_limit = v[9:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] sum_of(int unsigned k);
            logic [63:0] s;
            s = 0;
            for (int j = 0; j < 9; j++)
            begin
                s += store[k][j];
            end
            return s;
        endfunction

        function void resample();
            int unsigned n;
            int unsigned q;
            int unsigned a;
            int unsigned f;
            int unsigned b;
            logic [31:0] v;
            logic [8:0][14:0] px;
            out_item_t o;
            n = (n_stored == 0) ? 1 : n_stored;
            for (int unsigned i = 0; i < OUTF; i++)
            begin
                q = (i * (n - 1) * 32) / (OUTF - 1);
                a = q >> 5;
                f = q & 31;
                b = (f != 0 && a + 1 < n) ? a + 1 : a;
                if (a >= n) a = n - 1;
                for (int j = 0; j < 9; j++)
                begin
                    v = store[a][j] * (32 - f) + store[b][j] * f;
                    px[j] = v[14:0];
                end
                o.out0 = px[0]; o.out1 = px[1]; o.out2 = px[2];
                o.out3 = px[3]; o.out4 = px[4]; o.out5 = px[5];
                o.out6 = px[6]; o.out7 = px[7]; o.out8 = px[8];
                o.sample_index = i[4:0];
                o.last_frame = (i == OUTF - 1);
                expected_frames.push_back(o);
            end
        endfunction

        function void note_frame(in_item_t d);
            int unsigned slot;
            logic [63:0] s16;
            logic [63:0] s32;
            logic [63:0] lo;
            logic [63:0] hi;
            bit dev;
            frame_t fr;
            fr = to_frame(d);
            slot = (n_stored < MAXF) ? n_stored : MAXF - 1;
            for (int j = 0; j < 9; j++)
            begin
                store[slot][j] = fr[j];
            end
            n_stored = slot + 1;
            s16 = sum_of(slot) << 16;
            if (init_pend)
            begin
                base_q16 = s16;
                for (int j = 0; j < 9; j++)
                begin
                    ref_frame[j] = fr[j];
                end
                init_pend = 0;
            end
            else
            begin
                s32 = s16 << 16;
                lo = base_q16 * (64'd65536 - margin);
                hi = base_q16 * (64'd65536 + margin);
                if (s32 >= lo && s32 <= hi)
                begin
                    if (active)
                    begin
                        countdown = 3;
                        active = 0;
                    end
                    dev = 0;
                    for (int j = 0; j < 9; j++)
                    begin
                        if ((fr[j] > ref_frame[j] ? fr[j] - ref_frame[j]
                                                  : ref_frame[j] - fr[j]) > dev_limit)
                            dev = 1;
                    end
                    if (dev)
                        base_q16 = (base_q16 * (64'd65536 - alpha) + s16 * alpha) >> 16;
                end
                else
                begin
                    active = 1;
                end
            end
            if (countdown > 0)
            begin
                countdown--;
                if (countdown == 0)
                begin
                    resample();
                    return;
                end
            end
            if (!active && countdown == 0 && n_stored > 3)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int j = 0; j < 9; j++)
                    begin
                        store[k][j] = store[n_stored - 3 + k][j];
                    end
                end
                n_stored = 3;
            end
            if (n_stored > MAXF - 3)
            begin
                base_q16 = sum_of(n_stored - 1) << 16;
                for (int j = 0; j < 9; j++)
                begin
                    ref_frame[j] = store[n_stored - 1][j];
                end
                active = 0;
                countdown = 0;
                n_stored = 0;
                init_pend = 1;
            end
        endfunction

        function void check_frame(out_item_t got);
            out_item_t e;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected output frame %h", got);
                errors++;
                return;
            end
            e = expected_frames.pop_front();
            if (got.out0 != e.out0) begin $error("out0 exp %0d got %0d", e.out0, got.out0); errors++; end
            if (got.out1 != e.out1) begin $error("out1 exp %0d got %0d", e.out1, got.out1); errors++; end
            if (got.out2 != e.out2) begin $error("out2 exp %0d got %0d", e.out2, got.out2); errors++; end
            if (got.out3 != e.out3) begin $error("out3 exp %0d got %0d", e.out3, got.out3); errors++; end
            if (got.out4 != e.out4) begin $error("out4 exp %0d got %0d", e.out4, got.out4); errors++; end
            if (got.out5 != e.out5) begin $error("out5 exp %0d got %0d", e.out5, got.out5); errors++; end
            if (got.out6 != e.out6) begin $error("out6 exp %0d got %0d", e.out6, got.out6); errors++; end
            if (got.out7 != e.out7) begin $error("out7 exp %0d got %0d", e.out7, got.out7); errors++; end
            if (got.out8 != e.out8) begin $error("out8 exp %0d got %0d", e.out8, got.out8); errors++; end
            if (got.sample_index != e.sample_index)
            begin
                $error("sample_index exp %0d got %0d", e.sample_index, got.sample_index);
                errors++;
            end
            if (got.last_frame != e.last_frame)
            begin
                $error("last_frame exp %0d got %0d", e.last_frame, got.last_frame);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gesture_scoreboard sb;
    int hold_req;
    int hold_seen;
    int hold_off;
    bit stall_mode;

    gesture_segmenter_resampler u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    initial
    begin
        #50ms;
        $display("FAIL gesture_segmenter_resampler");
        $finish;
    end

    // receiver: random stall pattern in stall mode, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            hold_off <= 0;
            hold_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_frame(out_data);
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_off <= 400;
                out_ready <= 0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 0;
            end
            else if (stall_mode)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= 1;
        end
    end

    function automatic in_item_t make_frame(int unsigned lvl, int unsigned spread);
        in_item_t d;
        frame_t f;
        int v;
        for (int j = 0; j < 9; j++)
        begin
            v = int'(lvl) + int'($urandom_range(0, 2 * spread)) - int'(spread);
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            f[j] = v[9:0];
        end
        d = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]};
        return d;
    endfunction

    task automatic send_frame(in_item_t d);
        in_valid <= 1;
        in_data <= d;
        do @(posedge clk); while (!in_ready);
        sb.note_frame(d);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.expected_frames.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // quiet frames, a burst of loud ones, then quiet frames to finish the gesture
    task automatic gesture(int unsigned quiet_lvl, int unsigned loud_len);
        for (int k = 0; k < 2; k++)
        begin
            send_frame(make_frame(quiet_lvl, 8));
            gap();
        end
        for (int unsigned k = 0; k < loud_len; k++)
        begin
            send_frame(make_frame($urandom_range(0, 1) ? 1023 : 0, 40));
            gap();
        end
        for (int k = 0; k < 3; k++)
        begin
            send_frame(make_frame(quiet_lvl, 8));
            gap();
        end
    endtask

    int items;

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = CFG_EMA_WEIGHT;
        cfg_data = '0;
        hold_req = 0;
        stall_mode = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, gesture, deviation adaptation
        send_frame('0);
        send_frame('1);
        send_frame('0);
        send_frame(make_frame(500, 0));
        send_frame(make_frame(500, 0));
        send_frame(make_frame(500, 200));
        send_frame('1);
        send_frame('1);
        send_frame(make_frame(500, 0));
        send_frame(make_frame(500, 0));
        send_frame(make_frame(500, 0));
        send_frame({9{10'h2AA}});
        send_frame({9{10'h155}});
        drain();

        // long gesture overflows the store
        write_cfg(CFG_BAND_MARGIN, 16'd0);
        send_frame(make_frame(300, 0));
        for (int k = 0; k < 40; k++)
            send_frame(make_frame($urandom_range(0, 1023), 300));
        drain();

        write_cfg(CFG_EMA_WEIGHT, 16'hFFFF);
        write_cfg(CFG_BAND_MARGIN, 16'hFFFF);
        write_cfg(CFG_PIX_LIMIT, 16'd0);
        for (int k = 0; k < 12; k++)
            send_frame(make_frame($urandom_range(0, 1023), 500));
        drain();

        write_cfg(CFG_EMA_WEIGHT, 16'd0);
        write_cfg(CFG_BAND_MARGIN, 16'd3000);
        write_cfg(CFG_PIX_LIMIT, 16'd1023);
        stall_mode = 1;
        items = 0;
        while (items < 280)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_frame(make_frame($urandom_range(0, 1023), 512));
                    items++;
                end
                1:
                begin
                    hold_req++;
                    gesture($urandom_range(100, 900), 3);
                    items += 8;
                    gesture($urandom_range(100, 900), 2);
                    items += 7;
                end
                2:
                begin
                    drain();
                    write_cfg(cfg_idx_t'($urandom_range(0, 2)), 16'($urandom_range(0, 16'hFFFF)));
                    write_cfg(CFG_BAND_MARGIN, 16'($urandom_range(1000, 12000)));
                end
                3:
                begin
                    drain();
                    stall_mode = $urandom_range(0, 1);
                end
                default:
                begin
                    int unsigned loud;
                    loud = $urandom_range(1, 12);
                    gesture($urandom_range(50, 980), loud);
                    items += 5 + int'(loud);
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        drain();
        if (sb.expected_frames.size() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("PASS gesture_segmenter_resampler");
        else
            $display("FAIL gesture_segmenter_resampler");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/gsr_pkg.sv
rtl/core/gsr_frame_store.sv
rtl/core/gsr_mul.sv
rtl/core/gsr_lerp.sv
rtl/core/gesture_segmenter_resampler.sv
rtl/core/gsr_checker.sv
dv/tb.sv
